// ===== src/tshap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tshap_pkg;

  typedef enum logic [3:0] {
    G_IDLE     = 4'd0,
    G_HDR      = 4'd1,
    G_AFLEN    = 4'd2,
    G_AFFLAGS  = 4'd3,
    G_PCR      = 4'd4,
    G_OPCR     = 4'd5,
    G_SPLICE   = 4'd6,
    G_PRIVLEN  = 4'd7,
    G_PRIVDATA = 4'd8,
    G_EXTLEN   = 4'd9,
    G_EXTFLAGS = 4'd10,
    G_LTW      = 4'd11,
    G_PR       = 4'd12,
    G_SS       = 4'd13
  } group_e;

  localparam int unsigned MaxRec    = 8;
  localparam int unsigned CntW      = 4;
  localparam int unsigned CodeW     = 6;
  localparam int unsigned ValW      = 33;
  localparam int unsigned AccW      = 48;
  localparam int unsigned PidBits   = 13;
  localparam int unsigned RateBits  = 22;
  localparam int unsigned DtsBits   = 15;
  localparam int unsigned ExtBits   = 9;
  localparam int unsigned FifoDepth = 16;
  localparam int unsigned FifoAw    = 4;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [ValW-1:0]  value;
    logic             last;
  } rec_t;

  // The records caused by one byte, in stream order.
  typedef struct packed {
    rec_t [MaxRec-1:0] rec;
    logic [CntW-1:0]   count;
  } batch_t;

  function automatic rec_t mk(input int unsigned code, input logic [ValW-1:0] v);
    rec_t r;
    r.code  = CodeW'(code);
    r.value = v;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/tshap_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Parse state machine: one byte in, a batch of records out in the same cycle.
module tshap_parse (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic [7:0]             data_byte_i,
  input  wire logic                   packet_start_i,
  output tshap_pkg::batch_t           batch_o
);

  tshap_pkg::group_e            grp_q, grp_d;
  logic [2:0]                   k_q, k_d;
  logic [tshap_pkg::AccW-1:0]   acc_q, acc_d;
  logic [7:0]                   af_q, af_d;
  logic [2:0]                   ef_q, ef_d;
  logic [7:0]                   pl_q, pl_d;
  logic                         ha_q, ha_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= tshap_pkg::G_IDLE;
      k_q   <= '0;
      acc_q <= '0;
      af_q  <= '0;
      ef_q  <= '0;
      pl_q  <= '0;
      ha_q  <= 1'b0;
    end else if (en_i) begin
      grp_q <= grp_d;
      k_q   <= k_d;
      acc_q <= acc_d;
      af_q  <= af_d;
      ef_q  <= ef_d;
      pl_q  <= pl_d;
      ha_q  <= ha_d;
    end
  end

  // Next optional group after g, given the flags.
  function automatic tshap_pkg::group_e next_grp(input logic [3:0] g,
                                                 input logic [7:0] af,
                                                 input logic [2:0] ef);
    tshap_pkg::group_e r;
    r = tshap_pkg::G_IDLE;
    if      (g < 4'd4  && af[4]) r = tshap_pkg::G_PCR;
    else if (g < 4'd5  && af[3]) r = tshap_pkg::G_OPCR;
    else if (g < 4'd6  && af[2]) r = tshap_pkg::G_SPLICE;
    else if (g < 4'd7  && af[1]) r = tshap_pkg::G_PRIVLEN;
    else if (g < 4'd9  && af[0]) r = tshap_pkg::G_EXTLEN;
    else if (g < 4'd11 && ef[2]) r = tshap_pkg::G_LTW;
    else if (g < 4'd12 && ef[1]) r = tshap_pkg::G_PR;
    else if (g < 4'd13 && ef[0]) r = tshap_pkg::G_SS;
    return r;
  endfunction

  // Byte decode and record generation.
  always_comb begin
    tshap_pkg::group_e g;
    logic [2:0] k;
    logic [7:0] af, ef8, pl, b;
    logic [2:0] ef;
    logic [tshap_pkg::AccW-1:0] acc;
    logic       fin, ent;
    tshap_pkg::group_e tgt;
    logic [3:0] fin_from;
    logic [tshap_pkg::CntW-1:0] n;
    tshap_pkg::rec_t [tshap_pkg::MaxRec-1:0] r;

    g = grp_q; k = k_q; af = af_q; ef = ef_q; pl = pl_q; ha_d = ha_q;
    acc = acc_q; b = data_byte_i;
    fin = 1'b0; ent = 1'b0; tgt = tshap_pkg::G_IDLE; fin_from = 4'd0;
    n = '0; r = '0; ef8 = '0;
    if (packet_start_i) begin
      g = tshap_pkg::G_HDR; k = '0; acc = '0; af = '0; ef = '0; pl = '0; ha_d = 1'b0;
    end
    acc = {acc[tshap_pkg::AccW-9:0], b};
    grp_d = g; k_d = k + 3'd1; acc_d = acc; af_d = af; ef_d = ef; pl_d = pl;
    unique case (g)
      tshap_pkg::G_IDLE: begin
        grp_d = g; k_d = k; acc_d = acc_q;
      end
      tshap_pkg::G_HDR: begin
        if (k == 3'd0) begin
          r[0] = tshap_pkg::mk(0, 33'(b)); n = 4'd1;
        end else if (k == 3'd1) begin
          r[0] = tshap_pkg::mk(1, 33'(b[7]));
          r[1] = tshap_pkg::mk(2, 33'(b[6]));
          r[2] = tshap_pkg::mk(3, 33'(b[5])); n = 4'd3;
        end else if (k == 3'd2) begin
          r[0] = tshap_pkg::mk(4, 33'(acc[tshap_pkg::PidBits-1:0])); n = 4'd1;
        end else begin
          r[0] = tshap_pkg::mk(5, 33'(b[7:6]));
          r[1] = tshap_pkg::mk(6, 33'(b[5:4]));
          r[2] = tshap_pkg::mk(7, 33'(b[3:0])); n = 4'd3;
          ha_d = b[5];
          ent = 1'b1;
          tgt = b[5] ? tshap_pkg::G_AFLEN : tshap_pkg::G_IDLE;
        end
      end
      tshap_pkg::G_AFLEN: begin
        r[0] = tshap_pkg::mk(8, 33'(b)); n = 4'd1;
        ent = 1'b1;
        tgt = (b == 8'd0) ? tshap_pkg::G_IDLE : tshap_pkg::G_AFFLAGS;
      end
      tshap_pkg::G_AFFLAGS: begin
        for (int i = 0; i < 8; i++) begin
          r[i] = tshap_pkg::mk(9 + i, 33'(b[7-i]));
        end
        n = 4'd8;
        af = b; af_d = b;
        fin = 1'b1; fin_from = 4'd3;
      end
      tshap_pkg::G_PCR, tshap_pkg::G_OPCR: begin
        if (k == 3'd4) begin
          r[0] = tshap_pkg::mk(g == tshap_pkg::G_PCR ? 19 : 22, acc[39:7]);
          r[1] = tshap_pkg::mk(g == tshap_pkg::G_PCR ? 18 : 21, 33'(acc[6:1]));
          n = 4'd2;
        end else if (k >= 3'd5) begin
          r[0] = tshap_pkg::mk(g == tshap_pkg::G_PCR ? 17 : 20,
                               33'(acc[tshap_pkg::ExtBits-1:0]));
          n = 4'd1;
          fin = 1'b1; fin_from = 4'(g);
        end
      end
      tshap_pkg::G_SPLICE: begin
        r[0] = tshap_pkg::mk(23, 33'(b)); n = 4'd1;
        fin = 1'b1; fin_from = 4'd6;
      end
      tshap_pkg::G_PRIVLEN: begin
        r[0] = tshap_pkg::mk(24, 33'(b)); n = 4'd1;
        pl_d = b;
        if (b == 8'd0) begin
          fin = 1'b1; fin_from = 4'd8;
        end else begin
          ent = 1'b1; tgt = tshap_pkg::G_PRIVDATA;
        end
      end
      tshap_pkg::G_PRIVDATA: begin
        r[0] = tshap_pkg::mk(25, 33'(b)); n = 4'd1;
        pl_d = pl - 8'd1;
        if (pl == 8'd1) begin
          fin = 1'b1; fin_from = 4'd8;
        end
      end
      tshap_pkg::G_EXTLEN: begin
        r[0] = tshap_pkg::mk(26, 33'(b)); n = 4'd1;
        ent = 1'b1; tgt = tshap_pkg::G_EXTFLAGS;
      end
      tshap_pkg::G_EXTFLAGS: begin
        r[0] = tshap_pkg::mk(27, 33'(b[7]));
        r[1] = tshap_pkg::mk(28, 33'(b[6]));
        r[2] = tshap_pkg::mk(29, 33'(b[5]));
        r[3] = tshap_pkg::mk(30, 33'(b[4:0])); n = 4'd4;
        ef = b[7:5]; ef_d = b[7:5];
        fin = 1'b1; fin_from = 4'd10;
      end
      tshap_pkg::G_LTW: begin
        if (k >= 3'd1) begin
          r[0] = tshap_pkg::mk(31, 33'(acc[tshap_pkg::DtsBits]));
          r[1] = tshap_pkg::mk(32, 33'(acc[tshap_pkg::DtsBits-1:0])); n = 4'd2;
          fin = 1'b1; fin_from = 4'd11;
        end
      end
      tshap_pkg::G_PR: begin
        if (k == 3'd0) begin
          r[0] = tshap_pkg::mk(33, 33'(b[7:6])); n = 4'd1;
        end else if (k >= 3'd2) begin
          r[0] = tshap_pkg::mk(34, 33'(acc[tshap_pkg::RateBits-1:0])); n = 4'd1;
          fin = 1'b1; fin_from = 4'd12;
        end
      end
      tshap_pkg::G_SS: begin
        if (k == 3'd0) begin
          r[0] = tshap_pkg::mk(35, 33'(b[7:4]));
          r[1] = tshap_pkg::mk(36, 33'(b[3:1]));
          r[2] = tshap_pkg::mk(37, 33'(b[0])); n = 4'd3;
        end else if (k == 3'd2 || k >= 3'd4) begin
          r[0] = tshap_pkg::mk(k == 3'd2 ? 38 : 40, 33'(acc[tshap_pkg::DtsBits:1]));
          r[1] = tshap_pkg::mk(k == 3'd2 ? 39 : 41, 33'(acc[0])); n = 4'd2;
          if (k >= 3'd4) begin
            fin = 1'b1; fin_from = 4'd13;
          end
        end
      end
      default: begin
        ent = 1'b1; tgt = tshap_pkg::G_IDLE;
      end
    endcase
    ef8 = {5'd0, ef};
    if (fin) begin
      ent = 1'b1;
      tgt = next_grp(fin_from, af, ef8[2:0]);
    end
    if (ent) begin
      grp_d = tgt; k_d = '0; acc_d = '0;
    end
    for (int i = 0; i < tshap_pkg::MaxRec; i++) begin
      if (n != '0 && 4'(i) == n - 4'd1) r[i].last = 1'b1;
    end
    batch_o.rec   = r;
    batch_o.count = n;
  end

endmodule
`default_nettype wire

// ===== src/tshap_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Record queue: writes a whole batch of up to eight words, reads one a cycle.
module tshap_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tshap_pkg::batch_t batch_i,
  input  wire logic              push_i,
  output logic                   room_o,
  output logic                   valid_o,
  input  wire logic              pop_i,
  output tshap_pkg::rec_t        rec_o
);

  tshap_pkg::rec_t [tshap_pkg::FifoDepth-1:0] mem_q;
  logic [tshap_pkg::FifoAw-1:0] rd_q, wr_q;
  logic [tshap_pkg::FifoAw:0]   cnt_q, cnt_d;
  logic                         pop;

  assign pop     = pop_i && valid_o;
  assign valid_o = cnt_q != '0;
  assign rec_o   = mem_q[rd_q];
  // Room for a full batch: depth minus eight.
  assign room_o  = cnt_q <= 5'(tshap_pkg::FifoDepth - tshap_pkg::MaxRec);
  assign cnt_d   = cnt_q + (push_i ? 5'(batch_i.count) : 5'd0) - (pop ? 5'd1 : 5'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (pop) rd_q <= rd_q + 4'd1;
      if (push_i) wr_q <= wr_q + batch_i.count;
    end
  end

  // Batch write into consecutive slots.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = 0; i < tshap_pkg::MaxRec; i++) begin
        if (4'(i) < batch_i.count) mem_q[wr_q + 4'(i)] <= batch_i.rec[i];
      end
    end
  end

  ovf_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'(tshap_pkg::FifoDepth)) else $error("record queue overflow");
  push_room_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o) else $error("batch pushed without room");
  empty_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !valid_o) else $error("valid while empty");

endmodule
`default_nettype wire

// ===== src/ts_header_adaptation_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Transport-stream header and adaptation-field parser. One packet byte is taken
// per cycle; each byte is decoded in the same cycle it is accepted and the up to
// eight records it completes are written at once into a sixteen-word queue, which
// delivers one record per cycle while out_ready_i is high. Input is ready whenever
// the queue has room for a full batch of eight, so the sustained rate is one byte
// per cycle as long as bytes average at most one record each; a flags byte (eight
// records) can hold input off until the queue is back down to eight words. The
// records of a byte are registered in the queue, behind any still waiting there.
module ts_header_adaptation_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        packet_start_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       field_code_o,
  output logic [32:0]      field_value_o,
  output logic             last_of_run_o
);

  tshap_pkg::batch_t batch;
  tshap_pkg::rec_t   rec;
  logic              acc;

  assign acc = in_valid_i && in_ready_o;

  tshap_parse u_parse (
    .clk_i, .rst_ni, .en_i(acc), .data_byte_i, .packet_start_i, .batch_o(batch)
  );

  tshap_fifo u_fifo (
    .clk_i, .rst_ni, .batch_i(batch), .push_i(acc), .room_o(in_ready_o),
    .valid_o(out_valid_o), .pop_i(out_ready_i), .rec_o(rec)
  );

  assign field_code_o  = rec.code;
  assign field_value_o = rec.value;
  assign last_of_run_o = rec.last;

endmodule
`default_nettype wire
